// File: src/gcrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrb_pkg
// Shared types and constants for the gradient color ramp builder.
// ----------------------------------------------------------------------------
package gcrb_pkg;

	localparam int MAX_STOPS_DEF = 16;
	localparam int RAMP_SIZE_DEF = 256;
	localparam int ENTRIES_PER_RESULT = 4;
	localparam int LOC_W = 17;
	localparam logic [LOC_W-1:0] LOC_ONE = 17'h10000;

	typedef struct packed {
		logic        stop_valid;
		logic [16:0] stop_location;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_stop;
	} stop_item_t;

	typedef struct packed {
		logic [31:0] color_a;
		logic [31:0] color_b;
		logic [31:0] color_c;
		logic [31:0] color_d;
		logic [7:0]  first_index;
		logic [2:0]  entries_valid;
		logic        last_result;
		logic        stops_dropped;
	} ramp_beat_t;

endpackage

// File: src/gradient_color_ramp_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_ramp_builder_top
// Collects sorted color stops and emits a linearly interpolated color ramp.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall / item): one stop per beat, kept
// sorted by location; a stop goes after stops of equal location. A beat with
// last_stop set ends the set and starts ramp output.
// Output channel (ramp_valid / ramp_stall / ramp): four ramp entries per beat,
// RGBA packed red high. No stops gives one zero entry, one stop gives one
// entry; otherwise RAMP_SIZE entries in RAMP_SIZE/4 beats.
// Insertion moves each larger stop up one place, with a read and then a
// compare and write per place. Each interpolated entry runs four channels through
// one shared multiply-accumulate and restoring divider (one quotient bit per
// cycle), and each segment advance reloads the next stop from the store.
// item_stall stays high while a stop is inserted or a ramp is built. The
// beat register lets the next stop beat in while the final ramp beat waits.
// A stall on the output halts the sequencer at the next beat boundary.
// Reset clears the stop count and drop flag; the stop store needs no clear.
// ----------------------------------------------------------------------------
module gradient_color_ramp_builder_top #(
	parameter int MAX_STOPS = gcrb_pkg::MAX_STOPS_DEF,
	parameter int RAMP_SIZE = gcrb_pkg::RAMP_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  gcrb_pkg::stop_item_t item,
	output logic                ramp_valid,
	input  logic                ramp_stall,
	output gcrb_pkg::ramp_beat_t ramp
);
	import gcrb_pkg::*;

	localparam int AW    = $clog2(MAX_STOPS);
	localparam int CW    = $clog2(MAX_STOPS + 1);
	localparam int IW    = $clog2(RAMP_SIZE);
	localparam int STEPS = RAMP_SIZE - 1;
	localparam int SW    = $clog2(65536 * STEPS + 1);
	localparam int NW    = SW + 8;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ICHK  = 4'd1;
	localparam logic [3:0] ST_ICMP  = 4'd2;
	localparam logic [3:0] ST_RSTRT = 4'd3;
	localparam logic [3:0] ST_SGL   = 4'd4;
	localparam logic [3:0] ST_LD0   = 4'd5;
	localparam logic [3:0] ST_LD1   = 4'd6;
	localparam logic [3:0] ST_SAMP  = 4'd7;
	localparam logic [3:0] ST_ADV   = 4'd8;
	localparam logic [3:0] ST_MUL   = 4'd9;
	localparam logic [3:0] ST_DIV   = 4'd10;
	localparam logic [3:0] ST_STORE = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic ovf_q, last_q, single_q;
	logic [CW-1:0] ins_idx_q;
	logic [LOC_W-1:0] ins_loc_q;
	logic [31:0] ins_col_q;

	logic [LOC_W-1:0] pos_mem [MAX_STOPS];
	logic [31:0] col_mem [MAX_STOPS];
	logic [LOC_W-1:0] rd_pos_q;
	logic [31:0] rd_col_q;
	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [LOC_W-1:0] wr_pos;
	logic [31:0] wr_col;

	logic [CW-1:0] seg_q;
	logic [SW-1:0] lo_q, hi_q, den_q, n_q;
	logic [31:0] cl_q, cr_q, first_col_q, ent_q;
	logic [IW-1:0] idx_q;
	logic [1:0] ch_q;
	logic [2:0] bit_q;
	logic [NW-1:0] rem_q, dsh_q;
	logic [7:0] quo_q;
	logic [31:0] buf_q [ENTRIES_PER_RESULT];

	logic out_valid_q;
	ramp_beat_t out_q;

	logic [SW-1:0] x, rd_scaled;
	logic [LOC_W-1:0] in_loc;
	logic [7:0] cl_ch, cr_ch;
	logic [NW-1:0] num;
	logic ge;
	logic [NW-1:0] rem_nxt;
	logic [7:0] quo_nxt;
	logic out_free;
	logic seg_more;
	logic idx_last;

	assign item_stall = (state_q != ST_IDLE);
	assign ramp_valid = out_valid_q;
	assign ramp = out_q;
	assign out_free = !out_valid_q || !ramp_stall;

	assign x = SW'({idx_q, 16'h0000});
	assign rd_scaled = SW'(rd_pos_q * STEPS);
	assign in_loc = (item.stop_location > LOC_ONE) ? LOC_ONE : item.stop_location;
	assign cl_ch = cl_q[8*ch_q +: 8];
	assign cr_ch = cr_q[8*ch_q +: 8];
	assign num = NW'(cl_ch) * NW'(den_q - n_q) + NW'(cr_ch) * NW'(n_q) + NW'(den_q >> 1);
	assign ge = (rem_q >= dsh_q);
	assign rem_nxt = ge ? rem_q - dsh_q : rem_q;
	assign quo_nxt = {quo_q[6:0], ge};
	assign seg_more = (32'(seg_q) + 2 < 32'(count_q));
	assign idx_last = (idx_q == IW'(RAMP_SIZE - 1));

	// stop store: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_addr] <= wr_pos;
			col_mem[wr_addr] <= wr_col;
		end
		if (rd_en) begin
			rd_pos_q <= pos_mem[rd_addr];
			rd_col_q <= col_mem[rd_addr];
		end
	end

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = AW'(ins_idx_q);
		wr_pos = ins_loc_q;
		wr_col = ins_col_q;
		case (state_q)
			ST_ICHK: begin
				if (ins_idx_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = AW'(ins_idx_q - 1'b1);
				end
			end
			ST_ICMP: begin
				wr_en = 1'b1;
				if (ins_loc_q < rd_pos_q) begin
					wr_pos = rd_pos_q;
					wr_col = rd_col_q;
				end
			end
			ST_RSTRT: begin
				rd_en = 1'b1;
			end
			ST_LD0: begin
				rd_en = 1'b1;
				rd_addr = AW'(1);
			end
			ST_SAMP: begin
				rd_en = 1'b1;
				rd_addr = AW'(seg_q + 2'd2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
			single_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_EMIT the beat register is reloaded below instead
			if (out_valid_q && !ramp_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						last_q <= item.last_stop;
						ins_loc_q <= in_loc;
						ins_col_q <= {item.red, item.green, item.blue, item.alpha};
						ins_idx_q <= count_q;
						if (item.stop_valid && count_q < CW'(MAX_STOPS)) begin
							state_q <= ST_ICHK;
						end else begin
							if (item.stop_valid) begin
								ovf_q <= 1'b1;
							end
							if (item.last_stop) begin
								state_q <= ST_RSTRT;
							end
						end
					end
				end
				ST_ICHK: begin
					if (ins_idx_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= last_q ? ST_RSTRT : ST_IDLE;
					end else begin
						state_q <= ST_ICMP;
					end
				end
				ST_ICMP: begin
					if (ins_loc_q < rd_pos_q) begin
						ins_idx_q <= ins_idx_q - 1'b1;
						state_q <= ST_ICHK;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= last_q ? ST_RSTRT : ST_IDLE;
					end
				end
				ST_RSTRT: begin
					idx_q <= '0;
					single_q <= (count_q < CW'(2));
					for (int k = 0; k < ENTRIES_PER_RESULT; k++) begin
						buf_q[k] <= '0;
					end
					if (count_q == '0) begin
						state_q <= ST_EMIT;
					end else if (count_q == CW'(1)) begin
						state_q <= ST_SGL;
					end else begin
						state_q <= ST_LD0;
					end
				end
				ST_SGL: begin
					buf_q[0] <= rd_col_q;
					state_q <= ST_EMIT;
				end
				ST_LD0: begin
					lo_q <= rd_scaled;
					cl_q <= rd_col_q;
					first_col_q <= rd_col_q;
					state_q <= ST_LD1;
				end
				ST_LD1: begin
					hi_q <= rd_scaled;
					cr_q <= rd_col_q;
					seg_q <= '0;
					state_q <= ST_SAMP;
				end
				ST_SAMP: begin
					if (x < lo_q) begin
						ent_q <= first_col_q;
						state_q <= ST_STORE;
					end else if (seg_more && x > hi_q) begin
						seg_q <= seg_q + 1'b1;
						lo_q <= hi_q;
						cl_q <= cr_q;
						state_q <= ST_ADV;
					end else if (x > hi_q) begin
						ent_q <= cr_q;
						state_q <= ST_STORE;
					end else if (hi_q == lo_q) begin
						ent_q <= cl_q;
						state_q <= ST_STORE;
					end else begin
						n_q <= x - lo_q;
						den_q <= hi_q - lo_q;
						ch_q <= 2'd3;
						state_q <= ST_MUL;
					end
				end
				ST_ADV: begin
					hi_q <= rd_scaled;
					cr_q <= rd_col_q;
					state_q <= ST_SAMP;
				end
				ST_MUL: begin
					rem_q <= num;
					dsh_q <= NW'(den_q) << 7;
					bit_q <= 3'd7;
					quo_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_nxt;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						ent_q[8*ch_q +: 8] <= quo_nxt;
						if (ch_q == '0) begin
							state_q <= ST_STORE;
						end else begin
							ch_q <= ch_q - 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_STORE: begin
					buf_q[idx_q[1:0]] <= ent_q;
					if (idx_q[1:0] == 2'd3 || idx_last) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SAMP;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.color_a <= buf_q[0];
						out_q.color_b <= buf_q[1];
						out_q.color_c <= buf_q[2];
						out_q.color_d <= buf_q[3];
						out_q.first_index <= 8'({idx_q[IW-1:2], 2'b00});
						out_q.entries_valid <= 3'(idx_q[1:0]) + 3'd1;
						out_q.last_result <= single_q || idx_last;
						out_q.stops_dropped <= ovf_q;
						for (int k = 0; k < ENTRIES_PER_RESULT; k++) begin
							buf_q[k] <= '0;
						end
						if (single_q || idx_last) begin
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_SAMP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/gcrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrb_checker
// Port-level checks on the ramp output of the color ramp builder.
// ----------------------------------------------------------------------------
module gcrb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_stall,
	input logic                 ramp_valid,
	input logic                 ramp_stall,
	input gcrb_pkg::ramp_beat_t ramp
);
	import gcrb_pkg::*;

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_valid && ramp_stall |=> ramp_valid && $stable(ramp))
		else $error("ramp beat changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_valid |-> ramp.entries_valid != 3'd0 && ramp.entries_valid <= 3'd4)
		else $error("bad entries_valid");

	// a short beat can only close the ramp
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_valid && ramp.entries_valid != 3'd4 |-> ramp.last_result)
		else $error("short beat not last");

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_valid |-> ramp.first_index[1:0] == 2'b00)
		else $error("first_index not aligned");

	// mid-ramp the input side must be held off
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_valid && !ramp.last_result |-> item_stall)
		else $error("input open during ramp");

endmodule

bind gradient_color_ramp_builder_top gcrb_checker u_gcrb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_stall(item_stall),
	.ramp_valid(ramp_valid),
	.ramp_stall(ramp_stall),
	.ramp(ramp)
);
